// ===== design/wcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcc_pkg: shared types and constants
// Widths and the status struct passed between the correlation engine parts.
// ----------------------------------------------------------------------------
`default_nettype none
package wcc_pkg;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 48;
  localparam int QUO_W    = 32;
  localparam int LAGCFG_W = 7;
  localparam int LAGOUT_W = 6;
  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== design/windowed_cross_correlation.sv =====
// ----------------------------------------------------------------------------
// windowed_cross_correlation: windowed cross-correlation engine
// Stores sample pairs in two window RAMs and emits normalised lag sums.
// ----------------------------------------------------------------------------
// Usage. Items enter on in_valid/in_ready with in_action, in_x_sample and
// in_y_sample. A push item (action 0) writes one pair into the x and y
// window RAMs at the write pointer, so pushes stream one per cycle while
// the engine is idle. A compute item (action 1) walks the windows: it first
// sums the reference energy over the whole window, then for each lag m it
// multiplies and accumulates through the RAM read ports, divides the sum in
// the bit-serial divider and hands over the result. The multiply-accumulate
// walk and the divider set the time. Results leave on out_valid/out_ready
// from an output register; the engine waits in the handover state while
// the receiver stalls, and in_ready is low for the whole compute. lag_count
// is to be written by cfg_we/cfg_data only when idle; the block itself does
// not enforce this. Reset (rst_n low, synchronous) sets the write pointer
// to zero, lag_count to 32, and clears both RAMs with a pass over every
// address during which no item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_cross_correlation #(
  parameter int WINDOW = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic signed [15:0] in_x_sample,
  input  wire logic signed [15:0] in_y_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_lag_index,
  output logic signed [31:0] out_correlation,
  output logic             out_zero_reference,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data
);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REF, S_LAG, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [AW-1:0] wp_r, clr_r;
  logic [6:0]    lag_cfg_r;
  logic [LW-1:0] lags_r, m_r, n_r, cnt_r;
  logic          pend_r;   // read issued last cycle, data valid now
  logic          last_rd_r;
  logic signed [wcc_pkg::ACC_W-1:0] ref_r, acc_r;
  logic signed [wcc_pkg::PROD_W-1:0] prod;
  logic signed [15:0] xr, yr;
  logic [AW-1:0] xa, ya, wa;
  logic [AW:0]   xsum, ysum;
  logic          we;
  logic [15:0]   wx, wy;
  wcc_pkg::div_ctl_t dctl;
  logic          ddone;
  logic signed [31:0] dq;
  logic [LW-1:0] lags_eff;

  assign lags_eff = (lag_cfg_r > 7'(WINDOW)) ? LW'(WINDOW) : LW'(lag_cfg_r);

  // The offsets stay below twice the window, so one conditional subtract wraps.
  always_comb begin
    xsum = {1'b0, wp_r} + (AW+1)'(n_r) + (AW+1)'(m_r);
    ysum = {1'b0, wp_r} + (AW+1)'(n_r);
    xa = (xsum >= (AW+1)'(WINDOW)) ? AW'(xsum - (AW+1)'(WINDOW)) : xsum[AW-1:0];
    ya = (ysum >= (AW+1)'(WINDOW)) ? AW'(ysum - (AW+1)'(WINDOW)) : ysum[AW-1:0];
    if (state_r == S_REF) begin
      xa = ya;
    end
  end

  assign we = (state_r == S_CLEAR) ||
              (state_r == S_IDLE && in_valid && in_action == wcc_pkg::ACT_PUSH);
  assign wa = (state_r == S_CLEAR) ? clr_r : wp_r;
  assign wx = (state_r == S_CLEAR) ? 16'h0 : in_x_sample;
  assign wy = (state_r == S_CLEAR) ? 16'h0 : in_y_sample;

  wcc_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_xram (
    .clk(clk), .we(we), .waddr(wa), .wdata(wx), .raddr(xa), .rdata(xr));
  wcc_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_yram (
    .clk(clk), .we(we), .waddr(wa), .wdata(wy), .raddr(ya), .rdata(yr));

  assign prod = xr * yr;

  // The divider starts on the cycle the last product of the lag arrives.
  assign dctl.start = (state_r == S_LAG) && pend_r && (cnt_r == '0) && last_rd_r;
  assign dctl.busy  = (state_r == S_DIV);

  wcc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dctl.start), .num(acc_r + wcc_pkg::ACC_W'(prod)),
    .den(ref_r), .done(ddone), .quo(dq));

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      wp_r      <= '0;
      lag_cfg_r <= 7'd32;
      out_valid <= 1'b0;
      pend_r    <= 1'b0;
      last_rd_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lag_cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(WINDOW - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_action == wcc_pkg::ACT_PUSH) begin
              wp_r <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
            end else if (lags_eff >= LW'(2)) begin
              lags_r    <= lags_eff;
              state_r   <= S_REF;
              n_r       <= '0;
              m_r       <= '0;
              cnt_r     <= LW'(WINDOW);
              acc_r     <= '0;
              pend_r    <= 1'b0;
            end
          end
        end
        S_REF: begin
          // Reads issue while cnt_r > 0; each product accumulates in the next cycle.
          if (pend_r) begin
            acc_r <= acc_r + wcc_pkg::ACC_W'(prod);
          end
          if (cnt_r != '0) begin
            n_r    <= n_r + 1'b1;
            cnt_r  <= cnt_r - 1'b1;
            pend_r <= 1'b1;
          end else begin
            // The final product is still in flight here and joins the sum.
            ref_r     <= acc_r + (pend_r ? wcc_pkg::ACC_W'(prod) : '0);
            acc_r     <= '0;
            pend_r    <= 1'b0;
            m_r       <= LW'(1);
            n_r       <= '0;
            cnt_r     <= lags_r - LW'(1);
            last_rd_r <= 1'b0;
            state_r   <= S_LAG;
          end
        end
        S_LAG: begin
          if (pend_r) begin
            acc_r <= acc_r + wcc_pkg::ACC_W'(prod);
          end
          if (cnt_r != '0) begin
            cnt_r     <= cnt_r - 1'b1;
            pend_r    <= 1'b1;
            last_rd_r <= (cnt_r == LW'(1));
            n_r       <= (cnt_r == LW'(1)) ? '0 : n_r + 1'b1;
          end else begin
            pend_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            out_lag_index      <= m_r[5:0];
            out_zero_reference <= (ref_r == '0);
            out_correlation    <= (ref_r == '0) ? '0 : dq;
            out_last           <= (m_r + LW'(1) == lags_r);
            out_valid          <= 1'b1;
            state_r            <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            acc_r     <= '0;
            last_rd_r <= 1'b0;
            if (m_r + LW'(1) == lags_r) begin
              state_r <= S_IDLE;
            end else begin
              m_r     <= m_r + 1'b1;
              n_r     <= '0;
              cnt_r   <= lags_r - m_r - LW'(1);
              state_r <= S_LAG;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/wcc_ram.sv =====
// ----------------------------------------------------------------------------
// wcc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/wcc_div.sv =====
// ----------------------------------------------------------------------------
// wcc_div: signed restoring divider, one quotient bit per cycle
// Computes (num * 65536) / den truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module wcc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [wcc_pkg::ACC_W-1:0] num,
  input  wire logic signed [wcc_pkg::ACC_W-1:0] den,
  output logic                              done,
  output logic signed [wcc_pkg::QUO_W-1:0]  quo
);
  localparam int NW = wcc_pkg::ACC_W + 16;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]     n_r;
  logic [NW-1:0]     q_r;
  logic [NW:0]       rem_r;
  logic [NW-1:0]     d_r;
  logic              neg_r;
  logic              run_r;
  logic [CW-1:0]     cnt_r;
  logic [NW:0]       trial;
  logic [NW-1:0]     qmag;
  logic [NW:0]       qs;
  logic signed [NW:0] qv;

  logic [NW-1:0] an, ad;
  assign an = num[wcc_pkg::ACC_W-1] ? NW'(-{{16{num[wcc_pkg::ACC_W-1]}}, num}) << 16
                                     : NW'({{16{1'b0}}, num}) << 16;
  assign ad = den[wcc_pkg::ACC_W-1] ? NW'(-{{16{den[wcc_pkg::ACC_W-1]}}, den})
                                     : NW'({{16{1'b0}}, den});
  assign trial = {rem_r[NW-1:0], n_r[NW-1]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
    if (start) begin
      n_r   <= an;
      d_r   <= ad;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[wcc_pkg::ACC_W-1] ^ den[wcc_pkg::ACC_W-1];
    end else if (run_r) begin
      n_r <= {n_r[NW-2:0], 1'b0};
      if (!trial[NW]) begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[NW-1:0], n_r[NW-1]};
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign qmag = q_r;
  assign qs   = {1'b0, qmag};
  assign qv   = neg_r ? -$signed(qs) : $signed(qs);
  always_comb begin
    if (qv > $signed({{(NW-31){1'b0}}, 31'h7fffffff})) begin
      quo = 32'sh7fffffff;
    end else if (qv < -$signed({{(NW-31){1'b0}}, 31'h7fffffff}) - 1) begin
      quo = 32'sh80000000;
    end else begin
      quo = qv[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== design/wcc_checker.sv =====
// ----------------------------------------------------------------------------
// wcc_checker: port-level checks for windowed_cross_correlation
// Watches the handshakes and result flags over time.
// ----------------------------------------------------------------------------
`default_nettype none
module wcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_lag_index,
  input wire logic signed [31:0] out_correlation,
  input wire logic        out_zero_reference
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_correlation))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while a result waits");
  a_zero_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_reference |-> out_correlation == 32'sd0)
    else $error("zero reference with nonzero value");
  a_lag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lag_index != 6'd0)
    else $error("lag index zero");
endmodule

bind windowed_cross_correlation wcc_checker u_wcc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_lag_index(out_lag_index),
  .out_correlation(out_correlation), .out_zero_reference(out_zero_reference));
`default_nettype wire

// ===== test/tb_windowed_cross_correlation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_cross_correlation: self-checking bench for the correlation engine
// Streams sample pairs and compute commands under random idling on both
// channels, predicts every lag result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicted lag result.
typedef struct packed {
  logic [5:0]         lag;
  logic signed [31:0] corr;
  logic               zref;
  logic               last;
} lag_result_t;

// Scoreboard: its own copy of the windows, the pointer and the lag count.
class correlation_board;
  logic signed [15:0] x_win[64];
  logic signed [15:0] y_win[64];
  int unsigned        wr_ptr;
  logic [6:0]         lags_reg;
  lag_result_t        pending[$];
  int                 mismatches;

  function void clear();
    foreach (x_win[i]) begin
      x_win[i] = '0;
      y_win[i] = '0;
    end
    wr_ptr = 0;
    lags_reg = 7'd32;
    mismatches = 0;
  endfunction

  // Note an accepted input item and queue the results it causes.
  function void note_input(logic act, logic signed [15:0] xs, logic signed [15:0] ys);
    int unsigned  nl;
    int unsigned  base;
    longint       energy;
    longint       acc;
    longint       q;
    lag_result_t  r;
    if (act == wcc_pkg::ACT_PUSH) begin
      x_win[wr_ptr] = xs;
      y_win[wr_ptr] = ys;
      wr_ptr = (wr_ptr + 1) % 64;
      return;
    end
    base = wr_ptr;
    nl = (lags_reg > 64) ? 64 : lags_reg;
    energy = 0;
    for (int n = 0; n < 64; n++)
      energy += longint'(x_win[(base + n) % 64]) * longint'(y_win[(base + n) % 64]);
    for (int unsigned m = 1; m < nl; m++) begin
      acc = 0;
      for (int unsigned n = 0; n + m < nl; n++)
        acc += longint'(x_win[(base + n + m) % 64]) * longint'(y_win[(base + n) % 64]);
      q = 0;
      if (energy != 0) begin
        q = (acc * 65536) / energy;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      r.lag = m[5:0];
      r.corr = q[31:0];
      r.zref = (energy == 0);
      r.last = (m + 1 == nl);
      pending.push_back(r);
    end
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(lag_result_t got);
    lag_result_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result: lag %0d corr %0d", got.lag, got.corr);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected lag %0d corr %0d zref %0b last %0b, got lag %0d corr %0d zref %0b last %0b",
                 exp_r.lag, exp_r.corr, exp_r.zref, exp_r.last,
                 got.lag, got.corr, got.zref, got.last);
    end
  endfunction
endclass

module tb_windowed_cross_correlation;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = wcc_pkg::ACT_PUSH;
  logic signed [15:0] in_x_sample = '0;
  logic signed [15:0] in_y_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_lag_index;
  logic signed [31:0] out_correlation;
  logic out_zero_reference;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  correlation_board board = new();
  longint cycles = 0;
  bit     stim_done = 1'b0;

  windowed_cross_correlation #(.WINDOW(64)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_lag_index(out_lag_index),
    .out_correlation(out_correlation), .out_zero_reference(out_zero_reference),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Half the time no gap at all, otherwise mostly short gaps and now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Both handshakes are sampled at the rising edge, before the nonblocking
  // updates of that edge take effect, so the order of events does not matter.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready)
      board.note_input(in_action, in_x_sample, in_y_sample);
    if (rst_n && out_valid && out_ready)
      board.check_result('{out_lag_index, out_correlation, out_zero_reference, out_last});
  end

  // Receiver: ready toggles at random, with long stalls now and then.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = gap_length();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one item and holds it until the block takes it. Valid stays high
  // straight into the next item when no gap is drawn.
  task automatic send_item(logic act, logic signed [15:0] xs, logic signed [15:0] ys);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_x_sample <= xs;
    in_y_sample <= ys;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every predicted result has come back, then
  // lets the engine settle before the register may change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_lags(logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.lags_reg = value;
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++)
      send_item(wcc_pkg::ACT_PUSH, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [6:0] settings[6] = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd0, 7'd9};
    board.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A compute on the cleared windows gives a zero reference
    // with the reset lag count.
    send_item(wcc_pkg::ACT_COMPUTE, 16'sh7FFF, 16'sh8000);
    // Extremes of both samples, including the product of two most negative values.
    send_item(wcc_pkg::ACT_PUSH, 16'sh8000, 16'sh8000);
    send_item(wcc_pkg::ACT_PUSH, 16'sh7FFF, 16'sh7FFF);
    send_item(wcc_pkg::ACT_PUSH, 16'sh7FFF, 16'sh8000);
    send_item(wcc_pkg::ACT_PUSH, 16'sh8000, 16'sh7FFF);
    send_item(wcc_pkg::ACT_PUSH, 16'sh0001, 16'sh0001);
    send_item(wcc_pkg::ACT_PUSH, 16'shFFFF, 16'sh5555);
    send_item(wcc_pkg::ACT_PUSH, 16'shAAAA, 16'shFFFF);
    send_item(wcc_pkg::ACT_COMPUTE, '0, '0);
    // A tiny reference against large lag sums drives the quotient into saturation.
    drain();
    write_lags(7'd64);
    send_item(wcc_pkg::ACT_COMPUTE, '0, '0);
    drain();

    // Random phases under several lag counts, including the clamp above the
    // window and the counts that give no lags at all.
    foreach (settings[s]) begin
      if (s > 0) begin
        drain();
        write_lags(settings[s]);
      end
      for (int k = 0; k < 6; k++) begin
        push_random($urandom_range(1, 10));
        // Now and then a pair with a zero x sample and a random y sample.
        if ($urandom_range(0, 3) == 0)
          send_item(wcc_pkg::ACT_PUSH, 16'sh0000, 16'($urandom));
        send_item(wcc_pkg::ACT_COMPUTE, 16'($urandom), 16'($urandom));
      end
    end
    drain();
    write_lags(7'd32);
    push_random(20);
    send_item(wcc_pkg::ACT_COMPUTE, '0, '0);
    drain();

    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Completion and watchdog.
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end
endmodule

`default_nettype wire
